### sv/dtsg_pkg.sv
// Package: shared types, constants and the sine table lookup for the tone sweep generator.
`default_nettype none
package dtsg_pkg;

  localparam int PHASE_W          = 32;
  localparam int SAMPLE_W         = 8;
  localparam int TABLE_IDX_W      = 8;
  localparam int TABLE_DEPTH      = 256;
  localparam int SAMPLE_AMPLITUDE = 90;
  localparam int QUARTER          = TABLE_DEPTH / 4;
  localparam int HALF             = TABLE_DEPTH / 2;
  localparam int Q_W              = TABLE_IDX_W - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_INC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 2'd3;

  // state RAM layout: left entry holds {left_step, left_phase}, right entry holds right_phase
  localparam int ST_W     = 2 * PHASE_W;
  localparam int ST_DEPTH = 2;
  localparam logic ST_LEFT  = 1'b0;
  localparam logic ST_RIGHT = 1'b1;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef logic [SAMPLE_W-2:0] mag_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       last;
  } res_t;

  localparam mag_t QUARTER_WAVE [QUARTER+1] = '{
    7'd0,  7'd2,  7'd4,  7'd6,  7'd8,  7'd11, 7'd13, 7'd15,
    7'd17, 7'd19, 7'd21, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32,
    7'd34, 7'd36, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46, 7'd48,
    7'd50, 7'd51, 7'd53, 7'd55, 7'd57, 7'd58, 7'd60, 7'd62,
    7'd63, 7'd65, 7'd66, 7'd68, 7'd69, 7'd70, 7'd72, 7'd73,
    7'd74, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
    7'd83, 7'd83, 7'd84, 7'd85, 7'd86, 7'd86, 7'd87, 7'd87,
    7'd88, 7'd88, 7'd89, 7'd89, 7'd89, 7'd89, 7'd89, 7'd89,
    mag_t'(SAMPLE_AMPLITUDE)
  };

  function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
      input logic [TABLE_IDX_W-1:0] idx);
    logic [Q_W-1:0]         q;
    logic [TABLE_IDX_W-1:0] mirror;
    mag_t                   mag;
    q      = idx[Q_W-1:0];
    mirror = TABLE_IDX_W'(HALF) - {1'b0, q};
    if (q > Q_W'(QUARTER)) begin
      q = mirror[Q_W-1:0];
    end
    mag = QUARTER_WAVE[q];
    if (idx[TABLE_IDX_W-1]) begin
      sine_lookup = -$signed({1'b0, mag});
    end else begin
      sine_lookup = $signed({1'b0, mag});
    end
  endfunction

endpackage
`default_nettype wire

### sv/dtsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dtsg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/dds_tone_sweep_generator.sv
// Top level: NCO with linear chirp on the left channel, state held in a small RAM.
// Path to out_*: left via s1, sl and the buffer; right via s1, r1, sr and the buffer.
// No item is taken while the previous one is in s1; later stages do not block new items.
// Results queue in an OUT_DEPTH-entry buffer; items are taken only while room is reserved.
// Reset (rst_n low, synchronous) clears configuration, pipeline and buffer control.
// State RAM entries carry valid bits and read as zero until first written; no clearing pass.
`default_nettype none
module dds_tone_sweep_generator #(
  parameter int OUT_DEPTH = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_start_tone,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dtsg_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                                      out_channel,
  output logic                                      out_last,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic   [dtsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic   [dtsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int PW    = dtsg_pkg::PHASE_W;
  localparam int IW    = dtsg_pkg::TABLE_IDX_W;

  // configuration
  logic [PW-1:0] start_inc_r, sweep_r, right_inc_r;
  logic          stereo_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_inc_r <= '0;
      sweep_r     <= '0;
      right_inc_r <= '0;
      stereo_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtsg_pkg::CFG_START_INC: start_inc_r <= cfg_data[PW-1:0];
        dtsg_pkg::CFG_SWEEP:     sweep_r     <= cfg_data[PW-1:0];
        dtsg_pkg::CFG_RIGHT_INC: right_inc_r <= cfg_data[PW-1:0];
        dtsg_pkg::CFG_STEREO:    stereo_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control and payload
  logic          s1_vld_r, s1_start_r, s1_stereo_r;
  logic          r1_vld_r;
  logic          sl_vld_r, sl_last_r;
  logic [IW-1:0] sl_idx_r;
  logic          sr_vld_r;
  logic [IW-1:0] sr_idx_r;

  // result buffer
  dtsg_pkg::res_t buf_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, commit_r;
  logic [CNT_W-1:0] cnt_nxt, commit_nxt;

  logic in_acc, pop, push;
  dtsg_pkg::res_t push_res;

  assign in_stall = s1_vld_r || (commit_r > CNT_W'(OUT_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // state RAM
  logic                    ram_we, ram_re, ram_waddr, ram_raddr;
  logic [dtsg_pkg::ST_W-1:0] ram_wdata, ram_rdata, st_data;
  logic [dtsg_pkg::ST_DEPTH-1:0] st_vld_r;
  logic                    rd_vld_r;

  dtsg_ram #(
    .WIDTH(dtsg_pkg::ST_W),
    .DEPTH(dtsg_pkg::ST_DEPTH)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign st_data = rd_vld_r ? ram_rdata : '0;

  logic [PW-1:0] step0, l_phase, l_step, r_phase;

  always_comb begin
    step0   = s1_start_r ? start_inc_r : st_data[2*PW-1:PW];
    l_phase = st_data[PW-1:0] + step0;
    l_step  = step0 + sweep_r;
    r_phase = st_data[PW-1:0] + right_inc_r;

    ram_re    = 1'b0;
    ram_raddr = dtsg_pkg::ST_LEFT;
    if (in_acc) begin
      ram_re    = 1'b1;
      ram_raddr = dtsg_pkg::ST_LEFT;
    end else if (s1_vld_r && s1_stereo_r) begin
      ram_re    = 1'b1;
      ram_raddr = dtsg_pkg::ST_RIGHT;
    end

    ram_we    = 1'b0;
    ram_waddr = dtsg_pkg::ST_LEFT;
    ram_wdata = {l_step, l_phase};
    if (s1_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = dtsg_pkg::ST_LEFT;
      ram_wdata = {l_step, l_phase};
    end else if (r1_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = dtsg_pkg::ST_RIGHT;
      ram_wdata = {{PW{1'b0}}, r_phase};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ram_we) begin
        st_vld_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_r <= st_vld_r[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      r1_vld_r <= 1'b0;
      sl_vld_r <= 1'b0;
      sr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
      r1_vld_r <= s1_vld_r && s1_stereo_r;
      sl_vld_r <= s1_vld_r;
      sr_vld_r <= r1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start_r  <= in_start_tone;
      s1_stereo_r <= stereo_r;
    end
    if (s1_vld_r) begin
      sl_idx_r  <= l_phase[PW-1 -: IW];
      sl_last_r <= !s1_stereo_r;
    end
    if (r1_vld_r) begin
      sr_idx_r <= r_phase[PW-1 -: IW];
    end
  end

  // push left or right result into the buffer
  always_comb begin
    push = sl_vld_r || sr_vld_r;
    if (sr_vld_r) begin
      push_res.sample  = dtsg_pkg::sine_lookup(sr_idx_r);
      push_res.channel = dtsg_pkg::CH_RIGHT;
      push_res.last    = 1'b1;
    end else begin
      push_res.sample  = dtsg_pkg::sine_lookup(sl_idx_r);
      push_res.channel = dtsg_pkg::CH_LEFT;
      push_res.last    = sl_last_r;
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
    commit_nxt = commit_r - CNT_W'(pop);
    if (in_acc) begin
      commit_nxt = commit_nxt + (stereo_r ? CNT_W'(2) : CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      commit_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      commit_r <= commit_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_res;
    end
  end

  assign out_valid   = (cnt_r != '0);
  assign out_sample  = buf_r[rd_ptr_r].sample;
  assign out_channel = buf_r[rd_ptr_r].channel;
  assign out_last    = buf_r[rd_ptr_r].last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r != CNT_W'(OUT_DEPTH)))
    else $error("result buffer overflow");

  a_commit_covers: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= commit_r)
    else $error("buffer holds more results than reserved");

  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(sl_vld_r && sr_vld_r))
    else $error("left and right results collide");

  a_ram_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("state RAM read and write hit the same entry");

  a_right_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stereo_r) |-> ##3 sr_vld_r)
    else $error("stereo item lost its right result");

endmodule
`default_nettype wire
